// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked during reset as well.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/qstm_pkg.sv
package qstm_pkg;

  localparam int unsigned ROM_ENTRIES = 99;
  localparam int unsigned STR_BYTES   = 64;
  localparam logic [5:0]  COUNT_MAX   = 6'd63;

  typedef enum logic [1:0] {
    ACT_NAME      = 2'd0,
    ACT_VALUE     = 2'd1,
    ACT_END_VALUE = 2'd2,
    ACT_END_NAME  = 2'd3
  } action_t;

  // One word moving down the cell row.
  typedef struct packed {
    logic       valid;
    action_t    action;
    logic [7:0] data;
    logic [5:0] pos;   // byte position, or name length on an end word
    logic [5:0] vcnt;  // value length on an end word
    logic       found;
    logic [6:0] idx;
  } word_t;

  typedef logic [STR_BYTES-1:0][7:0] str_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  function automatic int unsigned str_len(input str_t s);
    int unsigned n;
    n = 0;
    for (int k = 0; k < STR_BYTES; k++) if (s[k] != 8'h00) n = k + 1;
    return n;
  endfunction

  function automatic str_t entry_name(input int unsigned id);
    str_t s;
    s = '0;
    case (id)
      0: s = ":authority";
      1: s = ":path";
      2: s = "age";
      3: s = "content-disposition";
      4: s = "content-length";
      5: s = "cookie";
      6: s = "date";
      7: s = "etag";
      8: s = "if-modified-since";
      9: s = "if-none-match";
      10: s = "last-modified";
      11: s = "link";
      12: s = "location";
      13: s = "referer";
      14: s = "set-cookie";
      15, 16, 17, 18, 19, 20, 21: s = ":method";
      22, 23: s = ":scheme";
      24, 25, 26, 27, 28: s = ":status";
      29, 30: s = "accept";
      31: s = "accept-encoding";
      32: s = "accept-ranges";
      33, 34: s = "access-control-allow-headers";
      35: s = "access-control-allow-origin";
      36, 37, 38, 39, 40, 41: s = "cache-control";
      42, 43: s = "content-encoding";
      44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 54: s = "content-type";
      55: s = "range";
      56, 57, 58: s = "strict-transport-security";
      59, 60: s = "vary";
      61: s = "x-content-type-options";
      62: s = "x-xss-protection";
      63, 64, 65, 66, 67, 68, 69, 70, 71: s = ":status";
      72: s = "accept-language";
      73, 74: s = "access-control-allow-credentials";
      75: s = "access-control-allow-headers";
      76, 77, 78: s = "access-control-allow-methods";
      79: s = "access-control-expose-headers";
      80: s = "access-control-request-headers";
      81, 82: s = "access-control-request-method";
      83: s = "alt-svc";
      84: s = "authorization";
      85: s = "content-security-policy";
      86: s = "early-data";
      87: s = "expect-ct";
      88: s = "forwarded";
      89: s = "if-range";
      90: s = "origin";
      91: s = "purpose";
      92: s = "server";
      93: s = "timing-allow-origin";
      94: s = "upgrade-insecure-requests";
      95: s = "user-agent";
      96: s = "x-forwarded-for";
      97, 98: s = "x-frame-options";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic str_t entry_value(input int unsigned id);
    str_t s;
    s = '0;
    case (id)
      1: s = "/";
      2: s = "0";
      4: s = "0";
      15: s = "CONNECT";
      16: s = "DELETE";
      17: s = "GET";
      18: s = "HEAD";
      19: s = "OPTIONS";
      20: s = "POST";
      21: s = "PUT";
      22: s = "http";
      23: s = "https";
      24: s = "103";
      25: s = "200";
      26: s = "304";
      27: s = "404";
      28: s = "503";
      29: s = "*/*";
      30: s = "application/dns-message";
      31: s = "gzip, deflate, br";
      32: s = "bytes";
      33: s = "cache-control";
      34: s = "content-type";
      35: s = "*";
      36: s = "max-age=0";
      37: s = "max-age=2592000";
      38: s = "max-age=604800";
      39: s = "no-cache";
      40: s = "no-store";
      41: s = "public, max-age=31536000";
      42: s = "br";
      43: s = "gzip";
      44: s = "application/dns-message";
      45: s = "application/javascript";
      46: s = "application/json";
      47: s = "application/x-www-form-urlencoded";
      48: s = "image/gif";
      49: s = "image/jpeg";
      50: s = "image/png";
      51: s = "text/css";
      52: s = "text/html; charset=utf-8";
      53: s = "text/plain";
      54: s = "text/plain;charset=utf-8";
      55: s = "bytes=0-";
      56: s = "max-age=31536000";
      57: s = "max-age=31536000; includesubdomains";
      58: s = "max-age=31536000; includesubdomains; preload";
      59: s = "accept-encoding";
      60: s = "origin";
      61: s = "nosniff";
      62: s = "1; mode=block";
      63: s = "100";
      64: s = "204";
      65: s = "206";
      66: s = "302";
      67: s = "400";
      68: s = "403";
      69: s = "421";
      70: s = "425";
      71: s = "500";
      73: s = "FALSE";
      74: s = "TRUE";
      75: s = "*";
      76: s = "get";
      77: s = "get, post, options";
      78: s = "options";
      79: s = "content-length";
      80: s = "content-type";
      81: s = "get";
      82: s = "post";
      83: s = "clear";
      85: s = "script-src 'none'; object-src 'none'; base-uri 'none'";
      86: s = "1";
      91: s = "prefetch";
      93: s = "*";
      94: s = "1";
      97: s = "deny";
      98: s = "sameorigin";
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/qstm_cell.sv
module qstm_cell
  import qstm_pkg::*;
#(
  parameter int unsigned ID = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  word_t word_in,
  output word_t word_out
);

  localparam str_t       NAME_B = entry_name(ID);
  localparam str_t       VAL_B  = entry_value(ID);
  localparam logic [6:0] NLEN   = 7'(str_len(NAME_B));
  localparam logic [6:0] VLEN   = 7'(str_len(VAL_B));

  logic nm_ok, nm_ok_next;
  logic val_ok, val_ok_next;
  logic [6:0] nm_diff, val_diff;
  logic nm_eq, val_eq, hit;
  word_t word_next;

  // Strings sit right-justified, so position p is byte len-1-p.
  always_comb begin
    nm_diff  = NLEN - 7'd1 - {1'b0, word_in.pos};
    val_diff = VLEN - 7'd1 - {1'b0, word_in.pos};
    nm_eq  = ({1'b0, word_in.pos} < NLEN) &&
             (fold(NAME_B[nm_diff[5:0]]) == fold(word_in.data));
    val_eq = ({1'b0, word_in.pos} < VLEN) && (VAL_B[val_diff[5:0]] == word_in.data);
    hit = (word_in.pos != 6'd0) && nm_ok && ({1'b0, word_in.pos} == NLEN) &&
          ((word_in.action == ACT_END_NAME) ||
           (val_ok && ({1'b0, word_in.vcnt} == VLEN)));
  end

  always_comb begin
    nm_ok_next  = nm_ok;
    val_ok_next = val_ok;
    word_next   = word_in;
    if (word_in.valid) begin
      case (word_in.action)
        ACT_NAME:  nm_ok_next  = nm_ok && nm_eq;
        ACT_VALUE: val_ok_next = val_ok && val_eq;
        default: begin
          nm_ok_next  = 1'b1;
          val_ok_next = 1'b1;
          if (!word_in.found && hit) begin
            word_next.found = 1'b1;
            word_next.idx   = 7'(ID);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_ok          <= 1'b1;
      val_ok         <= 1'b1;
      word_out.valid <= 1'b0;
    end else if (advance) begin
      nm_ok    <= nm_ok_next;
      val_ok   <= val_ok_next;
      word_out <= word_next;
    end
  end

endmodule

// File: rtl/qpack_static_table_match.sv
// QPACK static table matcher.
// Input channel (in_valid / in_stall): one word per query byte. action 0
// carries a name byte, 1 a value byte, 2 ends a query that includes the
// value, 3 ends a name-only query. Names compare case-folded, values exactly.
// Output channel (out_valid / out_stall): one word per end word, giving
// found and the lowest matching entry_index (zero when not found).
// Structure: a row of TABLE_ENTRIES cells, one per table entry. Every word
// walks the row one cell per cycle while the row advances; each cell narrows
// its own match bits as byte words pass, and an end word collects the first
// hit on its way. An end word passes through every cell and then the output
// register. Throughput: one word per cycle while in_stall is low.
// Stall: while a result waits and out_stall is high, the row keeps moving
// until an end word reaches its last cell; then the whole row and in_stall
// hold until the result is taken.
// Reset (rst, synchronous): all match bits set, byte counts zero, the row
// and the output register empty.
module qpack_static_table_match
  import qstm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = ROM_ENTRIES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       found,
  output logic [6:0] entry_index
);

  word_t chain [TABLE_ENTRIES+1];
  logic [5:0] ncnt, ncnt_next;
  logic [5:0] vcnt, vcnt_next;
  logic advance, accept, last_end;
  action_t act;

  assign act      = action_t'(action);
  assign last_end = chain[TABLE_ENTRIES].valid &&
                    (chain[TABLE_ENTRIES].action == ACT_END_VALUE ||
                     chain[TABLE_ENTRIES].action == ACT_END_NAME);
  // Freeze only when a finished result would collide with one still waiting.
  assign advance  = !(out_valid && out_stall && last_end);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Head: byte counters saturate; each word carries its position.
  always_comb begin
    ncnt_next = ncnt;
    vcnt_next = vcnt;
    chain[0].valid  = accept;
    chain[0].action = act;
    chain[0].data   = byte_value;
    chain[0].pos    = (act == ACT_VALUE) ? vcnt : ncnt;
    chain[0].vcnt   = vcnt;
    chain[0].found  = 1'b0;
    chain[0].idx    = 7'd0;
    if (accept) begin
      case (act)
        ACT_NAME:  if (ncnt != COUNT_MAX) ncnt_next = ncnt + 6'd1;
        ACT_VALUE: if (vcnt != COUNT_MAX) vcnt_next = vcnt + 6'd1;
        default: begin
          ncnt_next = 6'd0;
          vcnt_next = 6'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ncnt <= 6'd0;
      vcnt <= 6'd0;
    end else begin
      ncnt <= ncnt_next;
      vcnt <= vcnt_next;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    qstm_cell #(.ID(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .word_in  (chain[i]),
      .word_out (chain[i+1])
    );
  end

  // Output register: loads an end word leaving the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_end) begin
      out_valid   <= 1'b1;
      found       <= chain[TABLE_ENTRIES].found;
      entry_index <= chain[TABLE_ENTRIES].idx;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/qstm_checker.sv
`include "assert_macros.svh"

module qstm_checker
  import qstm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = ROM_ENTRIES
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] action,
  input logic [7:0] byte_value,
  input logic       out_valid,
  input logic       out_stall,
  input logic       found,
  input logic [6:0] entry_index
);

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(found) && $stable(entry_index))
  `ASSERT_CLK(a_miss_zero, out_valid && !found |-> entry_index == 7'd0)
  `ASSERT_CLK(a_idx_range, out_valid && found |-> 32'(entry_index) < TABLE_ENTRIES)
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid)
  `ASSERT_CLK(a_stall_cause, in_stall |-> out_valid && out_stall)

endmodule

bind qpack_static_table_match qstm_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_qstm_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import qstm_pkg::*;

  // Stall cycles counted by the watchdog before the run is declared hung.
  // A single result has to cross the whole cell row, and the long receiver
  // hold-off is LONG_HOLD, so this leaves a wide margin.
  localparam int HANG_LIMIT = 5000;
  localparam int N_ENTRIES  = 99;
  localparam int SAT_COUNT  = 63;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_WAIT = 120;  // cell row length plus slack

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] action;
  logic [7:0] byte_value;
  logic       out_valid;
  logic       out_stall;
  logic       found;
  logic [6:0] entry_index;

  qpack_static_table_match dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .byte_value (byte_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .entry_index(entry_index)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Static table, names and values, index order.
  string hdr_name [N_ENTRIES] = '{
    ":authority", ":path", "age", "content-disposition", "content-length",
    "cookie", "date", "etag", "if-modified-since", "if-none-match",
    "last-modified", "link", "location", "referer", "set-cookie",
    ":method", ":method", ":method", ":method", ":method", ":method", ":method",
    ":scheme", ":scheme",
    ":status", ":status", ":status", ":status", ":status",
    "accept", "accept", "accept-encoding", "accept-ranges",
    "access-control-allow-headers", "access-control-allow-headers",
    "access-control-allow-origin",
    "cache-control", "cache-control", "cache-control", "cache-control",
    "cache-control", "cache-control",
    "content-encoding", "content-encoding",
    "content-type", "content-type", "content-type", "content-type",
    "content-type", "content-type", "content-type", "content-type",
    "content-type", "content-type", "content-type",
    "range",
    "strict-transport-security", "strict-transport-security",
    "strict-transport-security",
    "vary", "vary", "x-content-type-options", "x-xss-protection",
    ":status", ":status", ":status", ":status", ":status", ":status",
    ":status", ":status", ":status",
    "accept-language",
    "access-control-allow-credentials", "access-control-allow-credentials",
    "access-control-allow-headers",
    "access-control-allow-methods", "access-control-allow-methods",
    "access-control-allow-methods",
    "access-control-expose-headers", "access-control-request-headers",
    "access-control-request-method", "access-control-request-method",
    "alt-svc", "authorization", "content-security-policy", "early-data",
    "expect-ct", "forwarded", "if-range", "origin", "purpose", "server",
    "timing-allow-origin", "upgrade-insecure-requests", "user-agent",
    "x-forwarded-for", "x-frame-options", "x-frame-options"
  };

  string hdr_value [N_ENTRIES] = '{
    "", "/", "0", "", "0", "", "", "", "", "", "", "", "", "", "",
    "CONNECT", "DELETE", "GET", "HEAD", "OPTIONS", "POST", "PUT",
    "http", "https",
    "103", "200", "304", "404", "503",
    "*/*", "application/dns-message", "gzip, deflate, br", "bytes",
    "cache-control", "content-type", "*",
    "max-age=0", "max-age=2592000", "max-age=604800", "no-cache", "no-store",
    "public, max-age=31536000",
    "br", "gzip",
    "application/dns-message", "application/javascript", "application/json",
    "application/x-www-form-urlencoded", "image/gif", "image/jpeg",
    "image/png", "text/css", "text/html; charset=utf-8", "text/plain",
    "text/plain;charset=utf-8",
    "bytes=0-",
    "max-age=31536000", "max-age=31536000; includesubdomains",
    "max-age=31536000; includesubdomains; preload",
    "accept-encoding", "origin", "nosniff", "1; mode=block",
    "100", "204", "206", "302", "400", "403", "421", "425", "500",
    "",
    "FALSE", "TRUE", "*",
    "get", "get, post, options", "options",
    "content-length", "content-type", "get", "post",
    "clear", "",
    "script-src 'none'; object-src 'none'; base-uri 'none'",
    "1", "", "", "", "", "prefetch", "", "*", "1", "", "", "deny",
    "sameorigin"
  };

  typedef struct {
    logic       hit;
    logic [6:0] idx;
  } lookup_t;

  // Predictor state: per-entry match bits, the two byte counts and the lookups due.
  bit      name_ok [N_ENTRIES];
  bit      val_ok  [N_ENTRIES];
  int      name_len_seen;
  int      val_len_seen;
  lookup_t lookups_due[$];

  int  err_cnt;
  int  results_seen;
  bit  sender_gaps;   // random idle bursts on the input side
  bit  recv_gaps;     // random stall bursts on the output side
  bit  long_hold_req;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic void clear_query();
    for (int i = 0; i < N_ENTRIES; i++) begin
      name_ok[i] = 1'b1;
      val_ok[i]  = 1'b1;
    end
    name_len_seen = 0;
    val_len_seen  = 0;
  endfunction

  // Advance the predictor by one accepted word.
  function automatic void predict_word(input action_t act, input logic [7:0] b);
    lookup_t r;
    string   s;
    case (act)
      ACT_NAME: begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          s = hdr_name[i];
          if (name_ok[i] && (name_len_seen >= s.len() ||
              lower_ascii(s[name_len_seen]) != lower_ascii(b)))
            name_ok[i] = 1'b0;
        end
        if (name_len_seen < SAT_COUNT) name_len_seen++;
      end
      ACT_VALUE: begin
        for (int i = 0; i < N_ENTRIES; i++) begin
          s = hdr_value[i];
          if (val_ok[i] && (val_len_seen >= s.len() || s[val_len_seen] != b))
            val_ok[i] = 1'b0;
        end
        if (val_len_seen < SAT_COUNT) val_len_seen++;
      end
      default: begin
        r.hit = 1'b0;
        r.idx = '0;
        if (name_len_seen != 0) begin
          for (int i = 0; i < N_ENTRIES; i++) begin
            if (!name_ok[i] || hdr_name[i].len() != name_len_seen) continue;
            if (act == ACT_END_VALUE &&
                (!val_ok[i] || hdr_value[i].len() != val_len_seen)) continue;
            r.hit = 1'b1;
            r.idx = i[6:0];
            break;
          end
        end
        lookups_due.push_back(r);
        clear_query();
      end
    endcase
  endfunction

  // Offer one word; returns after the edge that accepts it.
  task automatic send_word(input action_t act, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    byte_value <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_word(act, b);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Send a full query. Name letters may be flipped in case at random.
  task automatic send_query(input string nm, input string vl, input bit with_val,
                            input bit mix_case);
    logic [7:0] c;
    for (int k = 0; k < nm.len(); k++) begin
      c = nm[k];
      if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      send_word(ACT_NAME, c);
    end
    for (int k = 0; k < vl.len(); k++) send_word(ACT_VALUE, vl[k]);
    send_word(with_val ? ACT_END_VALUE : ACT_END_NAME, 8'h00);
  endtask

  task automatic wait_drained();
    idle_input();
    wait (lookups_due.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    int hold_cnt;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD) begin
          @(negedge clk);
          hold_cnt++;
        end
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!recv_gaps) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 11) - 1;
      end else begin
        out_stall <= 1'b0;
        burst = $urandom_range(1, 20) - 1;
      end
    end
  end

  // Result check against the oldest pending lookup.
  always @(posedge clk) begin
    lookup_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (lookups_due.size() == 0) begin
        $error("result word with nothing pending: found=%0d entry_index=%0d",
               found, entry_index);
        err_cnt++;
      end else begin
        e = lookups_due.pop_front();
        if (found !== e.hit) begin
          $error("found: expected %0d, actual %0d", e.hit, found);
          err_cnt++;
        end
        if (entry_index !== e.idx) begin
          $error("entry_index: expected %0d, actual %0d", e.idx, entry_index);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel.
  always @(posedge clk) begin
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else if (lookups_due.size() != 0 || in_valid) quiet++;
    if (quiet >= HANG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- tests ----

  // Exact hits and misses, names in mixed case, name-only and with value.
  task automatic test_known_entries();
    send_query(":authority", "", 1'b0, 1'b0);             // 0
    send_query(":AUTHORITY", "", 1'b1, 1'b0);             // empty value hit
    send_query(":path", "/", 1'b1, 1'b1);
    send_query(":method", "", 1'b0, 1'b1);                // lowest of 15..21
    send_query(":method", "PUT", 1'b1, 1'b0);
    send_query(":method", "put", 1'b1, 1'b0);             // value is exact
    send_query("content-type", "text/plain", 1'b1, 1'b1);
    send_query("x-frame-options", "sameorigin", 1'b1, 1'b0); // last entry
    send_query("cookie", "", 1'b1, 1'b0);
    send_query("content-length", "", 1'b1, 1'b0);         // value mismatch
    send_query("content", "", 1'b0, 1'b0);                // prefix only
    send_query("cache-control-x", "", 1'b0, 1'b0);        // too long
  endtask

  // Corner cases: empty name, saturated counts, high bytes, interleaving.
  task automatic test_corner_cases();
    send_word(ACT_END_NAME, 8'hFF);                       // empty name
    send_word(ACT_VALUE, "/");
    send_word(ACT_END_VALUE, 8'h00);                      // value, no name
    for (int k = 0; k < 70; k++) send_word(ACT_NAME, "a");
    send_word(ACT_END_NAME, 8'h00);
    send_query("age", "", 1'b0, 1'b0);
    for (int k = 0; k < 70; k++) send_word(ACT_VALUE, "0");
    send_word(ACT_END_VALUE, 8'h00);
    send_query("age", "0", 1'b1, 1'b0);
    send_word(ACT_NAME, 8'hC1);                           // not case folded
    send_word(ACT_NAME, 8'h80);
    send_word(ACT_END_NAME, 8'h00);
    send_word(ACT_NAME, "d");                             // name/value mixed
    send_word(ACT_VALUE, "g");
    send_word(ACT_NAME, "A");
    send_word(ACT_VALUE, "E");
    send_word(ACT_NAME, "t");
    send_word(ACT_VALUE, "T");
    send_word(ACT_NAME, "e");
    send_word(ACT_END_VALUE, 8'h00);
  endtask

  // Receiver holds off while words keep coming, so the row backs up.
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    for (int k = 0; k < 10; k++)
      send_query(hdr_name[$urandom_range(0, N_ENTRIES - 1)], "", 1'b0, 1'b1);
    wait_drained();
  endtask

  // Random queries: mostly table entries, some damaged, some plain noise.
  task automatic test_random_queries(input int words);
    int      i;
    int      n;
    int      kind;
    string   nm;
    string   vl;
    while (words > 0) begin
      kind = $urandom_range(0, 9);
      i    = $urandom_range(0, N_ENTRIES - 1);
      nm   = hdr_name[i];
      vl   = hdr_value[i];
      if (kind == 0) begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_word(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        words -= n;
      end else begin
        if (kind == 1 && nm.len() > 0)
          nm.putc($urandom_range(0, nm.len() - 1), $urandom_range(0, 255));
        if (kind == 2 && vl.len() > 0)
          vl.putc($urandom_range(0, vl.len() - 1), $urandom_range(0, 255));
        if (kind == 3) nm = nm.substr(0, nm.len() - 2);
        send_query(nm, vl, $urandom_range(0, 3) != 0, 1'b1);
        words -= nm.len() + vl.len() + 1;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_NAME;
    byte_value = 8'h00;
    err_cnt    = 0;
    results_seen = 0;
    sender_gaps  = 1'b0;
    recv_gaps    = 1'b0;
    long_hold_req = 1'b0;
    clear_query();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_known_entries();
    test_corner_cases();
    wait_drained();                 // sender pauses until all results are in
    sender_gaps = 1'b1;
    recv_gaps   = 1'b1;
    test_random_queries(130);
    test_output_backpressure();
    test_random_queries(130);
    sender_gaps = 1'b0;             // closing stretch at full rate
    recv_gaps   = 1'b0;
    test_random_queries(80);
    wait_drained();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
